### design/pld_pkg.sv
// Shared types and constants for the point-to-line distance pipeline.
package pld_pkg;

  localparam int unsigned DirFrac    = 14;
  localparam int unsigned SqrtStages = 16;

  typedef struct packed {
    logic [63:0]        sq;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               sat;
  } side_t;

endpackage

### design/pld_motion.sv
// Motion stages: t*V products, then moved positions with saturation.
module pld_motion import pld_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] pos_i [4],
  input  logic signed [31:0] vel_i [4],
  input  logic signed [31:0] time_i,
  output logic signed [31:0] mov_o [4],
  output logic               sat_o,
  output logic               valid_o
);

  logic signed [63:0] prod_q [4];
  logic signed [31:0] pos_q  [4];
  logic signed [31:0] mov_d  [4];
  logic [3:0]         sat_d;
  logic               vld_q;
  logic [3:0]         sat_q;

  always_comb begin
    logic signed [63:0] sum;
    for (int k = 0; k < 4; k++) begin
      sum = 64'(pos_q[k]) + (prod_q[k] >>> FracBits);
      if (sum > 64'sd2147483647) begin
        mov_d[k] = 32'sh7FFFFFFF;
        sat_d[k] = 1'b1;
      end else if (sum < -64'sd2147483648) begin
        mov_d[k] = 32'sh80000000;
        sat_d[k] = 1'b1;
      end else begin
        mov_d[k] = sum[31:0];
        sat_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= valid_i;
      valid_o <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= 64'(time_i) * 64'(vel_i[k]);
        pos_q[k]  <= pos_i[k];
        mov_o[k]  <= mov_d[k];
      end
      sat_q <= sat_d;
    end
  end

  assign sat_o = |sat_q;

endmodule

### design/pld_project.sv
// Projection stages: parameter s, closest point, squared distance.
module pld_project import pld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] mx_i,
  input  logic signed [31:0] my_i,
  input  logic signed [31:0] qx_i,
  input  logic signed [31:0] qy_i,
  input  logic signed [15:0] dx_i,
  input  logic signed [15:0] dy_i,
  input  logic               sat_i,
  output side_t              side_o,
  output logic               valid_o
);

  // Valid bits for the six stages.
  logic [5:0] vld_q;

  // Stage A: dot product terms.
  logic signed [48:0] pa_x_q, pa_y_q;
  // Stage B: projection parameter.
  logic signed [35:0] s_q;
  // Stage C: s*D.
  logic signed [51:0] pc_x_q, pc_y_q;
  // Stage D: closest point and error.
  logic signed [38:0] cx_q, cy_q;
  logic signed [39:0] ex_q, ey_q;
  // Stage E: squares.
  logic [63:0] sx_q, sy_q;
  logic        over_q;

  // Carried values per stage.
  logic signed [31:0] mx_q [3];
  logic signed [31:0] my_q [3];
  logic signed [31:0] qx_q [3];
  logic signed [31:0] qy_q [3];
  logic signed [15:0] dx_q [2];
  logic signed [15:0] dy_q [2];
  logic signed [38:0] cxe_q, cye_q;
  logic [4:0]         sat_q;

  logic signed [49:0] dot;
  logic signed [38:0] cx_d, cy_d;
  logic [39:0]        ax, ay;
  logic [64:0]        sum_sq;

  assign dot  = 50'(pa_x_q) + 50'(pa_y_q);
  assign cx_d = 39'(qx_q[2]) + 39'($signed(pc_x_q[51:DirFrac]));
  assign cy_d = 39'(qy_q[2]) + 39'($signed(pc_y_q[51:DirFrac]));
  assign ax   = ex_q[39] ? 40'(-ex_q) : 40'(ex_q);
  assign ay   = ey_q[39] ? 40'(-ey_q) : 40'(ey_q);
  assign sum_sq = 65'(sx_q) + 65'(sy_q);

  function automatic logic [32:0] clip32(input logic signed [38:0] v);
    if (v > 39'sd2147483647)       return {1'b1, 32'h7FFFFFFF};
    else if (v < -39'sd2147483648) return {1'b1, 32'h80000000};
    else                           return {1'b0, v[31:0]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] clx, cly;
    clx = clip32(cxe_q);
    cly = clip32(cye_q);
    if (en_i) begin
      pa_x_q <= 49'(dx_i) * 49'(33'(mx_i) - 33'(qx_i));
      pa_y_q <= 49'(dy_i) * 49'(33'(my_i) - 33'(qy_i));
      mx_q[0] <= mx_i;  my_q[0] <= my_i;
      qx_q[0] <= qx_i;  qy_q[0] <= qy_i;
      dx_q[0] <= dx_i;  dy_q[0] <= dy_i;
      sat_q[0] <= sat_i;

      s_q <= dot[49:DirFrac];
      mx_q[1] <= mx_q[0]; my_q[1] <= my_q[0];
      qx_q[1] <= qx_q[0]; qy_q[1] <= qy_q[0];
      dx_q[1] <= dx_q[0]; dy_q[1] <= dy_q[0];
      sat_q[1] <= sat_q[0];

      pc_x_q <= 52'(s_q) * 52'(dx_q[1]);
      pc_y_q <= 52'(s_q) * 52'(dy_q[1]);
      mx_q[2] <= mx_q[1]; my_q[2] <= my_q[1];
      qx_q[2] <= qx_q[1]; qy_q[2] <= qy_q[1];
      sat_q[2] <= sat_q[1];

      cx_q <= cx_d;
      cy_q <= cy_d;
      ex_q <= 40'(cx_d) - 40'(mx_q[2]);
      ey_q <= 40'(cy_d) - 40'(my_q[2]);
      sat_q[3] <= sat_q[2];

      sx_q   <= 64'(ax[31:0]) * 64'(ax[31:0]);
      sy_q   <= 64'(ay[31:0]) * 64'(ay[31:0]);
      over_q <= (|ax[39:32]) || (|ay[39:32]);
      cxe_q  <= cx_q;
      cye_q  <= cy_q;
      sat_q[4] <= sat_q[3];

      // Saturate the squared distance and the closest point.
      if (over_q || sum_sq[64]) begin
        side_o.sq <= '1;
      end else begin
        side_o.sq <= sum_sq[63:0];
      end
      side_o.cx  <= clx[31:0];
      side_o.cy  <= cly[31:0];
      side_o.sat <= sat_q[4] | over_q | sum_sq[64] | clx[32] | cly[32];
    end
  end

  assign valid_o = vld_q[5];

endmodule

### design/pld_sqrt.sv
// Pipelined digit-by-digit integer square root, two result bits per stage.
module pld_sqrt import pld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  output side_t       side_o,
  output logic [31:0] root_o,
  output logic        valid_o
);

  logic [SqrtStages-1:0] vld_q;
  logic [33:0]           rem_q  [SqrtStages];
  logic [31:0]           root_q [SqrtStages];
  logic [63:0]           rad_q  [SqrtStages];
  side_t                 side_q [SqrtStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SqrtStages-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
    logic [33:0] rem_in, rem_d;
    logic [31:0] root_in, root_d;
    logic [63:0] rad_in, rad_d;
    side_t       side_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = side_i.sq;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      logic [33:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      rad_d  = rad_in;
      for (int k = 0; k < 2; k++) begin
        rem_d = {rem_d[31:0], rad_d[63:62]};
        rad_d = {rad_d[61:0], 2'b00};
        trial = {root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[30:0], 1'b1};
        end else begin
          root_d = {root_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rad_q[g]  <= rad_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign side_o  = side_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];
  assign valid_o = vld_q[SqrtStages-1];

endmodule

### design/point_line_distance_2d_top.sv
// Top level of the moving point-to-line distance pipeline.
// A word is accepted every cycle while in_ready_o is high; it passes 25
// register stages: two motion stages, six projection stages, sixteen
// square-root stages (two root bits each) and the output register, the
// first of which loads at the accepting edge. The whole pipeline advances
// together: while a finished result waits at the output, every stage holds
// and in_ready_o is low, so nothing is lost or repeated.
module point_line_distance_2d_top import pld_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [31:0] time_t_i,
  input  logic signed [31:0] point_vel_x_i,
  input  logic signed [31:0] point_vel_y_i,
  input  logic signed [31:0] line_vel_x_i,
  input  logic signed [31:0] line_vel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        dist_squared_o,
  output logic [31:0]        dist_res_o,
  output logic signed [31:0] closest_x_o,
  output logic signed [31:0] closest_y_o,
  output logic               saturated_o
);

  logic               en;
  logic signed [31:0] pos [4];
  logic signed [31:0] vel [4];
  logic signed [31:0] mov [4];
  logic               mot_sat, mot_vld;
  logic signed [15:0] dx_q [2];
  logic signed [15:0] dy_q [2];
  side_t              prj_side, sq_side;
  logic               prj_vld, sq_vld;
  logic [31:0]        root;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign pos = '{point_x_i, point_y_i, origin_x_i, origin_y_i};
  assign vel = '{point_vel_x_i, point_vel_y_i, line_vel_x_i, line_vel_y_i};

  pld_motion #(.FracBits(FRAC_BITS)) u_motion (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .pos_i(pos), .vel_i(vel), .time_i(time_t_i),
    .mov_o(mov), .sat_o(mot_sat), .valid_o(mot_vld)
  );

  // The direction rides alongside the two motion stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0] <= dir_x_i;
      dy_q[0] <= dir_y_i;
      dx_q[1] <= dx_q[0];
      dy_q[1] <= dy_q[0];
    end
  end

  pld_project u_project (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mot_vld),
    .mx_i(mov[0]), .my_i(mov[1]), .qx_i(mov[2]), .qy_i(mov[3]),
    .dx_i(dx_q[1]), .dy_i(dy_q[1]), .sat_i(mot_sat),
    .side_o(prj_side), .valid_o(prj_vld)
  );

  pld_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(prj_vld),
    .side_i(prj_side), .side_o(sq_side), .root_o(root), .valid_o(sq_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_squared_o <= sq_side.sq;
      dist_res_o     <= root;
      closest_x_o    <= sq_side.cx;
      closest_y_o    <= sq_side.cy;
      saturated_o    <= sq_side.sat;
    end
  end

  a_root_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (64'(dist_res_o) * 64'(dist_res_o) <= dist_squared_o))
    else $error("root too large");

  a_root_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((66'(dist_res_o) + 66'd1) * (66'(dist_res_o) + 66'd1) > 66'(dist_squared_o)))
    else $error("root too small");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(dist_res_o)
      && $stable(dist_squared_o)))
    else $error("stalled result changed");

endmodule
